>>> rtl/core/rta_pkg.sv
package rta_pkg;

    localparam int TAG_SLOTS_DEFAULT = 256;

    localparam int TAG_W    = 16;
    localparam int REQ_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OWNER = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LIMIT = 1'd1;

    localparam logic [TAG_W-1:0] TAG_BASE_RESET  = 16'd0;
    localparam logic [TAG_W-1:0] TAG_LIMIT_RESET = 16'd255;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  requester_id;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag_out;
        logic [REQ_W-1:0]    owner_out;
    } rsp_t;

    typedef struct packed {
        logic [REQ_W-1:0] owner;
        logic             busy;
        logic             delivered;
    } slot_entry_t;

endpackage

>>> rtl/core/rta_slot_mem.sv
module rta_slot_mem #(
    parameter int DEPTH = rta_pkg::TAG_SLOTS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  rta_pkg::slot_entry_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output rta_pkg::slot_entry_t rdata
);

    rta_pkg::slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/rta_ctrl.sv
module rta_ctrl #(
    parameter int TAG_SLOTS = rta_pkg::TAG_SLOTS_DEFAULT,
    parameter int IDX_W     = $clog2(TAG_SLOTS),
    parameter int CNT_W     = $clog2(TAG_SLOTS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rta_pkg::cmd_t                   cmd,
    output logic                            done,
    output rta_pkg::rsp_t                   result,
    input  logic                            cfg_valid,
    input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rta_pkg::TAG_W-1:0]       cfg_data,
    output logic                            mem_we,
    output logic [IDX_W-1:0]                mem_waddr,
    output rta_pkg::slot_entry_t            mem_wdata,
    output logic                            mem_re,
    output logic [IDX_W-1:0]                mem_raddr,
    input  rta_pkg::slot_entry_t            mem_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAG_SLOTS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [rta_pkg::TAG_W-1:0]   tag_base_reg, tag_limit_reg;
    logic [CNT_W-1:0]            busy_count_reg, busy_count_next;
    logic [CNT_W-1:0]            window_reg, window_next;
    logic [IDX_W-1:0]            hint_reg, hint_next;
    logic [IDX_W-1:0]            ptr_reg, ptr_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    rta_pkg::cmd_t               cmd_reg, cmd_next;
    logic                        done_reg, done_next;
    rta_pkg::rsp_t               result_reg, result_next;

    logic [rta_pkg::TAG_W-1:0]   tag_off;
    logic                        in_win;
    logic [IDX_W-1:0]            cmd_idx;
    logic [rta_pkg::TAG_W-1:0]   diff;
    logic [CNT_W-1:0]            range;
    logic                        need_grow;
    logic [CNT_W:0]              dbl;
    logic [CNT_W-1:0]            grown;
    logic [CNT_W-1:0]            win_new;
    logic [IDX_W-1:0]            hint_new;
    logic [IDX_W-1:0]            scan_start;
    logic [CNT_W-1:0]            ptr_inc;
    logic [IDX_W-1:0]            ptr_wrap;
    logic [IDX_W-1:0]            cmd_reg_idx;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_base_reg  <= rta_pkg::TAG_BASE_RESET;
            tag_limit_reg <= rta_pkg::TAG_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rta_pkg::CFG_TAG_BASE:  tag_base_reg  <= cfg_data;
                rta_pkg::CFG_TAG_LIMIT: tag_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window check of the incoming tag.
    assign tag_off = cmd.tag - tag_base_reg;
    assign in_win  = (cmd.tag >= tag_base_reg) && (tag_off < rta_pkg::TAG_W'(window_reg));
    assign cmd_idx = tag_off[IDX_W-1:0];
    assign cmd_reg_idx = ptr_reg;

    // Window growth for allocate.
    assign diff  = tag_limit_reg - tag_base_reg;
    assign range = (tag_limit_reg <= tag_base_reg) ? '0 :
                   (diff > rta_pkg::TAG_W'(TAG_SLOTS)) ? CNT_W'(TAG_SLOTS) :
                   diff[CNT_W-1:0];
    assign need_grow = (busy_count_reg >= window_reg);
    assign dbl   = (window_reg == '0) ? (CNT_W+1)'(1) : {window_reg, 1'b0};
    assign grown = (dbl > {1'b0, range}) ? range : dbl[CNT_W-1:0];
    assign win_new  = need_grow ? grown : window_reg;
    assign hint_new = need_grow ? IDX_W'(window_reg) : hint_reg;
    assign scan_start = (CNT_W'(hint_new) < win_new) ? hint_new : '0;

    assign ptr_inc  = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_wrap = (ptr_inc >= window_reg) ? '0 : ptr_inc[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        busy_count_next = busy_count_reg;
        window_next     = window_reg;
        hint_next       = hint_reg;
        ptr_next        = ptr_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '0;
                ptr_next  = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        rta_pkg::KIND_ALLOC:
                        begin
                            state_next = S_PREP;
                        end
                        rta_pkg::KIND_RELEASE, rta_pkg::KIND_DELIVER:
                        begin
                            if (in_win)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = cmd_idx;
                                ptr_next   = cmd_idx;
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{rta_pkg::ST_RANGE, cmd.tag, '0};
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{rta_pkg::ST_OK, cmd.tag, '0};
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                done_next   = 1'b1;
                state_next  = S_IDLE;
                result_next = '{rta_pkg::ST_OK, cmd_reg.tag, '0};
                mem_waddr   = cmd_reg_idx;
                if (!mem_rdata.busy)
                begin
                    result_next.status = rta_pkg::ST_EMPTY;
                end
                else if (cmd_reg.kind == rta_pkg::KIND_RELEASE)
                begin
                    if (mem_rdata.owner != cmd_reg.requester_id)
                    begin
                        result_next.status = rta_pkg::ST_OWNER;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = '{mem_rdata.owner, 1'b0, 1'b0};
                        if (busy_count_reg != '0)
                        begin
                            busy_count_next = busy_count_reg - CNT_W'(1);
                        end
                        hint_next = cmd_reg_idx;
                    end
                end
                else if (mem_rdata.delivered)
                begin
                    result_next.status = rta_pkg::ST_EMPTY;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{mem_rdata.owner, 1'b1, 1'b1};
                    result_next.owner_out = mem_rdata.owner;
                end
            end

            S_PREP:
            begin
                if (need_grow && (window_reg >= range))
                begin
                    done_next   = 1'b1;
                    result_next = '{rta_pkg::ST_FULL, '0, '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    window_next = win_new;
                    hint_next   = hint_new;
                    mem_re      = 1'b1;
                    mem_raddr   = scan_start;
                    ptr_next    = scan_start;
                    n_next      = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!mem_rdata.busy)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = ptr_reg;
                    mem_wdata       = '{cmd_reg.requester_id, 1'b1, 1'b0};
                    busy_count_next = busy_count_reg + CNT_W'(1);
                    done_next       = 1'b1;
                    result_next     = '{rta_pkg::ST_OK,
                                        tag_base_reg + rta_pkg::TAG_W'(ptr_reg), '0};
                    state_next      = S_IDLE;
                end
                else if ((n_reg + CNT_W'(1)) >= window_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{rta_pkg::ST_FULL, '0, '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_wrap;
                    ptr_next  = ptr_wrap;
                    n_next    = n_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            busy_count_reg <= '0;
            window_reg     <= '0;
            hint_reg       <= '0;
            ptr_reg        <= '0;
            n_reg          <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_count_reg <= busy_count_next;
            window_reg     <= window_next;
            hint_reg       <= hint_next;
            ptr_reg        <= ptr_next;
            n_reg          <= n_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

endmodule

>>> rtl/core/rpc_tag_allocator.sv
// Release and deliver raise the done strobe once the slot is read and checked; an out-of-window
// tag and the no-operation kind answer straight from idle. Allocate reads slots from the slot
// memory, one per cycle, until a free one is found (at most the window size), or answers full
// without a read when the window cannot grow. One item is in flight at a time; the receiver
// cannot stall the result. After reset the block clears the slot memory with busy high.
module rpc_tag_allocator #(
    parameter int TAG_SLOTS = rta_pkg::TAG_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rta_pkg::cmd_t                 cmd,
    output logic                          done,
    output rta_pkg::rsp_t                 result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rta_pkg::TAG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TAG_SLOTS);
    localparam int CNT_W = $clog2(TAG_SLOTS + 1);

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    rta_pkg::slot_entry_t mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    rta_pkg::slot_entry_t mem_rdata;

    assign cfg_ready = 1'b1;

    rta_ctrl #(
        .TAG_SLOTS (TAG_SLOTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    rta_slot_mem #(
        .DEPTH (TAG_SLOTS),
        .AW    (IDX_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> sim/tb_rpc_tag_allocator.sv
module tb_rpc_tag_allocator;
    import rta_pkg::*;

    localparam int TAG_SLOTS = TAG_SLOTS_DEFAULT;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic done;
    rsp_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TAG_W-1:0] cfg_data = '0;

    rpc_tag_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [TAG_W-1:0] tag_base_q = TAG_BASE_RESET;
    logic [TAG_W-1:0] tag_limit_q = TAG_LIMIT_RESET;
    bit [REQ_W-1:0] slot_owner [TAG_SLOTS];
    bit slot_busy [TAG_SLOTS];
    bit slot_delivered [TAG_SLOTS];
    int busy_slots = 0;
    int window_size = 0;
    int free_hint = 0;

    cmd_t cmd_backlog [$];
    rsp_t awaited_rsps [$];
    rsp_t want;
    int idle_pct = 0;
    int mismatches = 0;

    function automatic int tag_range();
        int r;
        r = 0;
        if (tag_limit_q > tag_base_q)
            r = tag_limit_q - tag_base_q;
        if (r > TAG_SLOTS)
            r = TAG_SLOTS;
        return r;
    endfunction

    function automatic int window_slot(logic [TAG_W-1:0] t);
        int off;
        if (t < tag_base_q)
            return -1;
        off = t - tag_base_q;
        if (off >= window_size || off >= TAG_SLOTS)
            return -1;
        return off;
    endfunction

    function automatic rsp_t allocator_response(cmd_t c);
        rsp_t r;
        int range_now;
        int grown;
        int first;
        int idx;
        r.status = ST_OK;
        r.tag_out = c.tag;
        r.owner_out = '0;
        case (c.kind)
            KIND_ALLOC:
            begin
                r.status = ST_FULL;
                r.tag_out = '0;
                range_now = tag_range();
                if (busy_slots >= window_size)
                begin
                    if (window_size >= range_now)
                        return r;
                    grown = (window_size == 0) ? 1 : window_size * 2;
                    if (grown > range_now)
                        grown = range_now;
                    free_hint = window_size;
                    window_size = grown;
                end
                first = (free_hint < window_size) ? free_hint : 0;
                for (int n = 0; n < window_size; n++)
                begin
                    idx = first + n;
                    if (idx >= window_size)
                        idx -= window_size;
                    if (!slot_busy[idx])
                    begin
                        slot_busy[idx] = 1'b1;
                        slot_delivered[idx] = 1'b0;
                        slot_owner[idx] = c.requester_id;
                        busy_slots++;
                        r.status = ST_OK;
                        r.tag_out = tag_base_q + TAG_W'(idx);
                        return r;
                    end
                end
            end
            KIND_RELEASE:
            begin
                idx = window_slot(c.tag);
                if (idx < 0)
                    r.status = ST_RANGE;
                else if (!slot_busy[idx])
                    r.status = ST_EMPTY;
                else if (slot_owner[idx] != c.requester_id)
                    r.status = ST_OWNER;
                else
                begin
                    slot_busy[idx] = 1'b0;
                    slot_delivered[idx] = 1'b0;
                    if (busy_slots > 0)
                        busy_slots--;
                    free_hint = idx;
                end
            end
            KIND_DELIVER:
            begin
                idx = window_slot(c.tag);
                if (idx < 0)
                    r.status = ST_RANGE;
                else if (!slot_busy[idx] || slot_delivered[idx])
                    r.status = ST_EMPTY;
                else
                begin
                    slot_delivered[idx] = 1'b1;
                    r.owner_out = slot_owner[idx];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_busy_slot();
        int first;
        int idx;
        if (busy_slots == 0 || window_size == 0)
            return -1;
        first = $urandom_range(window_size - 1);
        for (int n = 0; n < window_size; n++)
        begin
            idx = (first + n) % window_size;
            if (slot_busy[idx])
                return idx;
        end
        return -1;
    endfunction

    function automatic cmd_t random_cmd(int alloc_pct);
        cmd_t c;
        int roll;
        int idx;
        c.kind = KIND_ALLOC;
        c.requester_id = REQ_W'($urandom);
        c.tag = TAG_W'($urandom);
        roll = $urandom_range(99);
        idx = pick_busy_slot();
        if (roll < alloc_pct)
            c.kind = KIND_ALLOC;
        else if (roll < 92 && idx >= 0)
        begin
            c.kind = ($urandom_range(1) == 0) ? KIND_RELEASE : KIND_DELIVER;
            c.tag = tag_base_q + TAG_W'(idx);
            if ($urandom_range(9) != 0)
                c.requester_id = slot_owner[idx];
        end
        else
        begin
            c.kind = KIND_W'($urandom_range(3));
            case ($urandom_range(3))
                0: c.tag = tag_base_q - 1'b1;
                1: c.tag = tag_base_q + TAG_W'(window_size);
                2: c.tag = tag_base_q + TAG_W'($urandom_range(window_size));
                default: c.tag = TAG_W'($urandom);
            endcase
        end
        return c;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                awaited_rsps.push_back(allocator_response(cmd));
            if (!start || !busy)
            begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cmd <= cmd_backlog.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_rsps.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d tag_out %0h",
                       result.status, result.tag_out);
                mismatches++;
            end
            else
            begin
                want = awaited_rsps.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result.status);
                    mismatches++;
                end
                if (result.tag_out !== want.tag_out)
                begin
                    $error("tag_out: expected %0h, actual %0h", want.tag_out, result.tag_out);
                    mismatches++;
                end
                if (result.owner_out !== want.owner_out)
                begin
                    $error("owner_out: expected %0h, actual %0h",
                           want.owner_out, result.owner_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TAG_BASE: tag_base_q = val;
            CFG_TAG_LIMIT: tag_limit_q = val;
            default: ;
        endcase
    endtask

    task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [REQ_W-1:0] req,
                             input logic [TAG_W-1:0] t);
        cmd_t c;
        c.kind = k;
        c.requester_id = req;
        c.tag = t;
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() > 0 || start || awaited_rsps.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int count, input int alloc_pct, input int pause_at);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            while (cmd_backlog.size() >= 2)
                @(negedge clk);
            if (i == pause_at)
                wait_idle();
            cmd_backlog.push_back(random_cmd(alloc_pct));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // An empty tag range: every allocation is refused and no tag is in the window.
        set_reg(CFG_TAG_BASE, 16'hFFFF);
        set_reg(CFG_TAG_LIMIT, 16'h0000);
        @(negedge clk);
        queue_cmd(KIND_ALLOC, 8'hFF, 16'h0000);
        queue_cmd(KIND_RELEASE, 8'h00, 16'hFFFF);
        queue_cmd(KIND_DELIVER, 8'hFF, 16'h0000);
        queue_cmd(KIND_NOP, 8'hFF, 16'hFFFF);
        wait_idle();

        set_reg(CFG_TAG_BASE, 16'd100);
        set_reg(CFG_TAG_LIMIT, 16'd104);
        @(negedge clk);
        queue_cmd(KIND_ALLOC, 8'hFF, 16'hFFFF);
        queue_cmd(KIND_ALLOC, 8'h00, 16'h0000);
        queue_cmd(KIND_ALLOC, 8'h5A, 16'h1234);
        queue_cmd(KIND_ALLOC, 8'hA5, 16'h0000);
        queue_cmd(KIND_ALLOC, 8'h01, 16'h0000);
        queue_cmd(KIND_DELIVER, 8'h00, 16'd100);
        queue_cmd(KIND_DELIVER, 8'h00, 16'd100);
        queue_cmd(KIND_RELEASE, 8'h01, 16'd101);
        queue_cmd(KIND_RELEASE, 8'h00, 16'd101);
        queue_cmd(KIND_RELEASE, 8'h00, 16'd101);
        queue_cmd(KIND_DELIVER, 8'h00, 16'd101);
        queue_cmd(KIND_RELEASE, 8'hA5, 16'd99);
        queue_cmd(KIND_DELIVER, 8'h00, 16'd104);
        queue_cmd(KIND_DELIVER, 8'h00, 16'h0000);
        queue_cmd(KIND_ALLOC, 8'h77, 16'h0000);
        queue_cmd(KIND_RELEASE, 8'hFF, 16'd100);
        queue_cmd(KIND_NOP, 8'h00, 16'h0000);
        wait_idle();

        set_reg(CFG_TAG_BASE, 16'd65520);
        set_reg(CFG_TAG_LIMIT, 16'd65535);
        idle_pct = 0;
        run_random(400, 45, -1);
        wait_idle();

        set_reg(CFG_TAG_BASE, 16'd0);
        set_reg(CFG_TAG_LIMIT, 16'd65535);
        idle_pct = 53;
        run_random(600, 70, -1);
        wait_idle();

        // The window stays larger than the new range, so tags past the top wrap around.
        set_reg(CFG_TAG_BASE, 16'd65400);
        set_reg(CFG_TAG_LIMIT, 16'd65410);
        idle_pct = 0;
        run_random(400, 40, -1);
        wait_idle();

        set_reg(CFG_TAG_BASE, TAG_BASE_RESET);
        set_reg(CFG_TAG_LIMIT, TAG_LIMIT_RESET);
        idle_pct = 33;
        run_random(500, 38, 250);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("rpc_tag_allocator test passed");
        else
            $display("rpc_tag_allocator test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("rpc_tag_allocator test failed");
        $finish;
    end

endmodule
